// ===== rtl/core/heightmap_triangle_sampler_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_TOP_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define HTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hts: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hts: next-cycle check failed");

`endif

// ===== rtl/core/hts_pkg.sv =====
package hts_pkg;

	// field widths
	localparam int POS_W      = 24;
	localparam int SAMPLE_W   = 16;
	localparam int ROW_W      = 7;
	localparam int COL_W      = 7;
	localparam int GRID_REG_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// datapath widths
	localparam int PX_W  = 26;	// position plus offset minus half a cell
	localparam int Q_W   = 17;	// truncated cell index
	localparam int F_W   = 27;	// Q.9 fraction, extrapolation included
	localparam int W_W   = 28;	// triangle weight
	localparam int D_W   = 17;	// height difference
	localparam int P_W   = 45;	// weighted difference
	localparam int ACC_W = 47;	// Q.9 accumulator

	localparam int FRAC_BITS   = 9;
	localparam int ONE_Q9      = 512;
	localparam int HALF_Q9     = 256;
	localparam int OUT_MAX     = 8388607;
	localparam int OUT_MIN     = -8388608;
	localparam int GRID_RESET  = 128;
	localparam int COLS_MIN    = 3;
	localparam int ROWS_MIN    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_OFFSET,
		CFG_Z_OFFSET,
		CFG_GRID_COLUMNS,
		CFG_GRID_ROWS
	} cfg_reg_t;

endpackage

// ===== rtl/core/hts_ram.sv =====
module hts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/heightmap_triangle_sampler_top.sv =====
// Channel   Handshake              Word
// --------  ---------------------  ---------------------------------------------
// in        in_valid / in_ready    action, row, col, sample, x_pos, z_pos
// out       out_valid / out_ready  height_out
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// Seven pipeline stages; one word enters per cycle while in_ready is high;
// a query's result leaves from the stage 7 register, held while out_ready is low.
// Absent stalls, the sustained rate of one query per cycle comes from the height
// store being split into four banks by row and column parity: each cell corner
// sits in its own bank, so all four corners are read in a single cycle.
// arst_n clears the valid bits and the offsets and sets both grid sizes to 128;
// the height store is not cleared and holds garbage until written.
// A stall holds only the unbroken run of full stages at the output; the rest move.

module heightmap_triangle_sampler_top #(
	parameter int GRID_COLS = 128,
	parameter int GRID_ROWS = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [hts_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]         cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic [hts_pkg::ROW_W-1:0]              row,
	input  logic [hts_pkg::COL_W-1:0]              col,
	input  logic signed [hts_pkg::SAMPLE_W-1:0]    sample,
	input  logic signed [hts_pkg::POS_W-1:0]       x_pos,
	input  logic signed [hts_pkg::POS_W-1:0]       z_pos,

	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [hts_pkg::POS_W-1:0]       height_out
);

	// Bank geometry: bank {row parity, col parity} holds rows and cols halved.
	localparam int BANK_COLS  = (GRID_COLS + 1) / 2;
	localparam int BANK_ROWS  = (GRID_ROWS + 1) / 2;
	localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int CXW        = $clog2(GRID_COLS);
	localparam int RZW        = $clog2(GRID_ROWS);

	localparam int PX_W   = hts_pkg::PX_W;
	localparam int Q_W    = hts_pkg::Q_W;
	localparam int F_W    = hts_pkg::F_W;
	localparam int W_W    = hts_pkg::W_W;
	localparam int D_W    = hts_pkg::D_W;
	localparam int P_W    = hts_pkg::P_W;
	localparam int ACC_W  = hts_pkg::ACC_W;
	localparam int SW     = hts_pkg::SAMPLE_W;
	localparam int FB     = hts_pkg::FRAC_BITS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [hts_pkg::POS_W-1:0]  x_offset_q;
	logic signed [hts_pkg::POS_W-1:0]  z_offset_q;
	logic [hts_pkg::GRID_REG_W-1:0]    grid_columns_q;
	logic [hts_pkg::GRID_REG_W-1:0]    grid_rows_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q     <= '0;
			z_offset_q     <= '0;
			grid_columns_q <= hts_pkg::GRID_REG_W'(hts_pkg::GRID_RESET);
			grid_rows_q    <= hts_pkg::GRID_REG_W'(hts_pkg::GRID_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hts_pkg::CFG_X_OFFSET:     x_offset_q     <= cfg_data[hts_pkg::POS_W-1:0];
				hts_pkg::CFG_Z_OFFSET:     z_offset_q     <= cfg_data[hts_pkg::POS_W-1:0];
				hts_pkg::CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[hts_pkg::GRID_REG_W-1:0];
				hts_pkg::CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[hts_pkg::GRID_REG_W-1:0];
				default: ;	// indexes past the register list are dropped
			endcase
		end
	end

	// Upper clamp bounds for the cell index: columns in use minus two, rows
	// in use minus two, with the register first saturated to the legal range.
	logic [Q_W-1:0]        cols_ext, rows_ext, cols_eff, rows_eff;
	logic signed [Q_W-1:0] x_hi, z_hi;

	always_comb begin
		cols_ext = Q_W'(grid_columns_q);
		rows_ext = Q_W'(grid_rows_q);
		if (cols_ext < hts_pkg::COLS_MIN) begin
			cols_eff = Q_W'(hts_pkg::COLS_MIN);
		end else if (cols_ext > GRID_COLS) begin
			cols_eff = Q_W'(GRID_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		if (rows_ext < hts_pkg::ROWS_MIN) begin
			rows_eff = Q_W'(hts_pkg::ROWS_MIN);
		end else if (rows_ext > GRID_ROWS) begin
			rows_eff = Q_W'(GRID_ROWS);
		end else begin
			rows_eff = rows_ext;
		end
		x_hi = $signed(cols_eff - Q_W'(2));
		z_hi = $signed(rows_eff - Q_W'(2));
	end

	// ------------------------------------------------------------------
	// Stage handshake: a stage takes a new word when it is empty or when
	// the stage after it takes its current one.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 3 moves on exactly when its word reaches the banks.
	logic bank_go;
	assign bank_go = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			// write words end at the banks; only queries go on
			if (rdy_s4) v_s4 <= v_s3 && act_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	logic                          act_s1, act_s2, act_s3;
	logic [hts_pkg::ROW_W-1:0]     row_s1, row_s2, row_s3;
	logic [hts_pkg::COL_W-1:0]     col_s1, col_s2, col_s3;
	logic signed [SW-1:0]          sample_s1, sample_s2, sample_s3;
	logic signed [PX_W-1:0]        px_s1, pz_s1, px_s2, pz_s2;
	logic signed [Q_W-1:0]         qx_s2, qz_s2;
	logic [CXW-1:0]                cx_s3;
	logic [RZW-1:0]                cz_s3;
	logic signed [F_W-1:0]         fx_s3, fz_s3;
	logic                          xp_s4, zp_s4, lower_s4, lower_s5;
	logic signed [W_W-1:0]         w1_s4, w2_s4, w1_s5, w2_s5;
	logic signed [SW-1:0]          hb_s5, hb_s6;
	logic signed [D_W-1:0]         d1_s5, d2_s5;
	logic signed [P_W-1:0]         p1_s6, p2_s6;
	logic signed [hts_pkg::POS_W-1:0] height_s7;

	// stage 1: shift the position by offset minus half a cell
	logic signed [PX_W-1:0] px_nx, pz_nx;
	assign px_nx = PX_W'(x_pos) + PX_W'(x_offset_q) - PX_W'(hts_pkg::HALF_Q9);
	assign pz_nx = PX_W'(z_pos) + PX_W'(z_offset_q) - PX_W'(hts_pkg::HALF_Q9);

	// stage 2: cell index, truncated toward zero
	logic signed [Q_W-1:0] qx_nx, qz_nx;
	assign qx_nx = Q_W'(px_s1 >>> FB) + Q_W'((px_s1 < 0) && (px_s1[FB-1:0] != '0));
	assign qz_nx = Q_W'(pz_s1 >>> FB) + Q_W'((pz_s1 < 0) && (pz_s1[FB-1:0] != '0));

	// stage 3: clamp the cell and take the fraction relative to it
	logic signed [Q_W-1:0] cx_full, cz_full;
	logic signed [F_W-1:0] fx_nx, fz_nx;

	always_comb begin
		if (qx_s2 < 1) begin
			cx_full = Q_W'(1);
		end else if (qx_s2 > x_hi) begin
			cx_full = x_hi;
		end else begin
			cx_full = qx_s2;
		end
		if (qz_s2 < 0) begin
			cz_full = Q_W'(0);
		end else if (qz_s2 > z_hi) begin
			cz_full = z_hi;
		end else begin
			cz_full = qz_s2;
		end
		fx_nx = F_W'(px_s2) - (F_W'(cx_full) <<< FB);
		fz_nx = F_W'(pz_s2) - (F_W'(cz_full) <<< FB);
	end

	// stage 4: pick the triangle and its weights
	logic signed [W_W-1:0] fsum, w1_nx, w2_nx;
	logic                  lower_nx;

	always_comb begin
		fsum     = W_W'(fx_s3) + W_W'(fz_s3);
		lower_nx = fsum < hts_pkg::ONE_Q9;
		if (lower_nx) begin
			w1_nx = W_W'(fx_s3);
			w2_nx = W_W'(fz_s3);
		end else begin
			w1_nx = W_W'(hts_pkg::ONE_Q9) - W_W'(fz_s3);
			w2_nx = W_W'(hts_pkg::ONE_Q9) - W_W'(fx_s3);
		end
	end

	// ------------------------------------------------------------------
	// Height store: four banks by {row parity, col parity}. A write word in
	// stage 3 goes to one bank; a query reads all four corners at once.
	// Writes and reads share the same stage, so they stay in word order.
	// ------------------------------------------------------------------
	logic          wr_ok;
	logic [SW-1:0] bank_rdata [4];

	assign wr_ok = !act_s3 && (row_s3 < GRID_ROWS) && (col_s3 < GRID_COLS);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam bit PR = (b / 2) == 1;
		localparam bit PC = (b % 2) == 1;

		logic [RZW-1:0]     rd_row;
		logic [CXW-1:0]     rd_col;
		logic [BANK_AW-1:0] rd_addr, wr_addr, addr;
		logic               wr_hit;

		always_comb begin
			rd_row  = (cz_s3[0] == PR) ? cz_s3 : cz_s3 + RZW'(1);
			rd_col  = (cx_s3[0] == PC) ? cx_s3 : cx_s3 + CXW'(1);
			rd_addr = BANK_AW'(rd_row >> 1) * BANK_AW'(BANK_COLS) + BANK_AW'(rd_col >> 1);
			wr_addr = BANK_AW'(row_s3 >> 1) * BANK_AW'(BANK_COLS) + BANK_AW'(col_s3 >> 1);
			wr_hit  = wr_ok && (row_s3[0] == PR) && (col_s3[0] == PC);
			addr    = act_s3 ? rd_addr : wr_addr;
		end

		hts_ram #(
			.WIDTH(SW),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.en   (bank_go && (act_s3 || wr_hit)),
			.we   (!act_s3),
			.addr (addr),
			.wdata(sample_s3),
			.rdata(bank_rdata[b])
		);
	end

	// stage 5: route bank outputs to the cell corners
	logic signed [SW-1:0] col_a0, col_a1, col_b0, col_b1;
	logic signed [SW-1:0] h0, h1, h2, h3, hb_nx;

	always_comb begin
		// a: column cx, b: column cx+1, for bank row parity 0 and 1
		col_a0 = xp_s4 ? bank_rdata[1] : bank_rdata[0];
		col_b0 = xp_s4 ? bank_rdata[0] : bank_rdata[1];
		col_a1 = xp_s4 ? bank_rdata[3] : bank_rdata[2];
		col_b1 = xp_s4 ? bank_rdata[2] : bank_rdata[3];
		h0     = zp_s4 ? col_a1 : col_a0;
		h1     = zp_s4 ? col_b1 : col_b0;
		h2     = zp_s4 ? col_a0 : col_a1;
		h3     = zp_s4 ? col_b0 : col_b1;
		hb_nx  = lower_s4 ? h0 : h3;
	end

	// stage 7: sum, round to Q.0 (integer) and saturate
	logic signed [ACC_W-1:0] acc, acc_rnd;
	logic signed [hts_pkg::POS_W-1:0] height_nx;

	always_comb begin
		acc     = (ACC_W'(hb_s6) <<< FB) + ACC_W'(p1_s6) + ACC_W'(p2_s6)
		          + ACC_W'(hts_pkg::HALF_Q9);
		acc_rnd = acc >>> FB;
		if (acc_rnd > hts_pkg::OUT_MAX) begin
			height_nx = hts_pkg::POS_W'(hts_pkg::OUT_MAX);
		end else if (acc_rnd < hts_pkg::OUT_MIN) begin
			height_nx = hts_pkg::POS_W'(hts_pkg::OUT_MIN);
		end else begin
			height_nx = hts_pkg::POS_W'(acc_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			act_s1    <= action;
			row_s1    <= row;
			col_s1    <= col;
			sample_s1 <= sample;
			px_s1     <= px_nx;
			pz_s1     <= pz_nx;
		end
		if (rdy_s2) begin
			act_s2    <= act_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			sample_s2 <= sample_s1;
			px_s2     <= px_s1;
			pz_s2     <= pz_s1;
			qx_s2     <= qx_nx;
			qz_s2     <= qz_nx;
		end
		if (rdy_s3) begin
			act_s3    <= act_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			sample_s3 <= sample_s2;
			cx_s3     <= CXW'(cx_full);
			cz_s3     <= RZW'(cz_full);
			fx_s3     <= fx_nx;
			fz_s3     <= fz_nx;
		end
		if (rdy_s4) begin
			xp_s4    <= cx_s3[0];
			zp_s4    <= cz_s3[0];
			lower_s4 <= lower_nx;
			w1_s4    <= w1_nx;
			w2_s4    <= w2_nx;
		end
		if (rdy_s5) begin
			lower_s5 <= lower_s4;
			hb_s5    <= hb_nx;
			d1_s5    <= D_W'(h1) - D_W'(hb_nx);
			d2_s5    <= D_W'(h2) - D_W'(hb_nx);
			w1_s5    <= w1_s4;
			w2_s5    <= w2_s4;
		end
		if (rdy_s6) begin
			hb_s6 <= hb_s5;
			p1_s6 <= P_W'(d1_s5) * P_W'(w1_s5);
			p2_s6 <= P_W'(d2_s5) * P_W'(w2_s5);
		end
		if (rdy_s7) begin
			height_s7 <= height_nx;
		end
	end

	assign out_valid  = v_s7;
	assign height_out = height_s7;

endmodule

// ===== rtl/core/hts_checker.sv =====
`include "heightmap_triangle_sampler_top_defines.svh"

module hts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] height_out
);

	// input backs up only when every stage is full and the result is stalled
	`HTS_ASSERT_IMPL(a_in_stall_full, clk, arst_n, !in_ready, out_valid && !out_ready)

	// configuration writes are never refused
	`HTS_ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// a stalled result stays offered and unchanged
	`HTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`HTS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(height_out))

endmodule

bind heightmap_triangle_sampler_top hts_checker u_hts_checker (.*);

// ===== test/heightmap_triangle_sampler_top_tb.sv =====
`timescale 1ns / 1ps

module heightmap_triangle_sampler_top_tb;
	import hts_pkg::*;

	localparam int GRID_COLS     = 128;
	localparam int GRID_ROWS     = 128;
	localparam int STORE_DEPTH   = GRID_ROWS * GRID_COLS;
	localparam int PIPE_LATENCY  = 7;
	// writes leave no result behind, so let the pipe empty after the last height
	localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 2;
	localparam int RESET_CYCLES  = 12;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int PHASE_WORDS   = 85;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// index past the end of the register list; the block must drop it
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

	localparam logic signed [POS_W-1:0]    POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0]    POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct {
		logic                       action;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [POS_W-1:0]    x_pos;
		logic signed [POS_W-1:0]    z_pos;
	} grid_word_t;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_EVERY_THIRD
	} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       action = ACT_WRITE;
	logic [ROW_W-1:0]           row = '0;
	logic [COL_W-1:0]           col = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic signed [POS_W-1:0]    x_pos = '0;
	logic signed [POS_W-1:0]    z_pos = '0;

	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [POS_W-1:0]    height_out;

	// Words waiting to be sent, and heights the block still owes us.
	grid_word_t              pending_words[$];
	logic signed [POS_W-1:0] expected_heights[$];

	// Shadow of the block's configuration and height store.
	logic signed [POS_W-1:0]    x_offset_reg = '0;
	logic signed [POS_W-1:0]    z_offset_reg = '0;
	logic [GRID_REG_W-1:0]      columns_reg = GRID_RESET;
	logic [GRID_REG_W-1:0]      rows_reg = GRID_RESET;
	logic signed [SAMPLE_W-1:0] model_heights [STORE_DEPTH];

	// Cells the stimulus has written so far; queries only touch these.
	bit sample_written [STORE_DEPTH];

	int fail_count = 0;

	heightmap_triangle_sampler_top #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.row       (row),
		.col       (col),
		.sample    (sample),
		.x_pos     (x_pos),
		.z_pos     (z_pos),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.height_out(height_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Grid arithmetic, shared by stimulus (to find corners) and prediction
	// ------------------------------------------------------------------

	// Saturate a grid size register into the range the block supports.
	function automatic longint used_size(logic [GRID_REG_W-1:0] v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Position plus offset minus half a cell: a grid coordinate in Q.9.
	function automatic longint grid_coord(logic signed [POS_W-1:0] pos,
			logic signed [POS_W-1:0] offset);
		return longint'(pos) + longint'(offset) - HALF_Q9;
	endfunction

	// Truncate toward zero, then clamp the cell index.
	function automatic longint grid_cell(longint coord, longint lo, longint hi);
		longint c;
		c = coord / ONE_Q9;
		if (c < lo)
			return lo;
		if (c > hi)
			return hi;
		return c;
	endfunction

	function automatic longint cell_col(logic signed [POS_W-1:0] xp);
		return grid_cell(grid_coord(xp, x_offset_reg), 1,
			used_size(columns_reg, COLS_MIN, GRID_COLS) - 2);
	endfunction

	function automatic longint cell_row(logic signed [POS_W-1:0] zp);
		return grid_cell(grid_coord(zp, z_offset_reg), 0,
			used_size(rows_reg, ROWS_MIN, GRID_ROWS) - 2);
	endfunction

	// Expected height for a query: pick the triangle, weight the corners,
	// round half up to Q.0 (integer) and saturate to the output width.
	function automatic logic signed [POS_W-1:0] interp_height(
			logic signed [POS_W-1:0] xp, logic signed [POS_W-1:0] zp);
		longint px, pz, cx, cz, fx, fz;
		longint h0, h1, h2, h3, acc, res;
		px = grid_coord(xp, x_offset_reg);
		pz = grid_coord(zp, z_offset_reg);
		cx = cell_col(xp);
		cz = cell_row(zp);
		fx = px - cx * ONE_Q9;
		fz = pz - cz * ONE_Q9;
		h0 = model_heights[cz * GRID_COLS + cx];
		h1 = model_heights[cz * GRID_COLS + cx + 1];
		h2 = model_heights[(cz + 1) * GRID_COLS + cx];
		h3 = model_heights[(cz + 1) * GRID_COLS + cx + 1];
		if (fx + fz < ONE_Q9)
			acc = h0 * ONE_Q9 + (h1 - h0) * fx + (h2 - h0) * fz;
		else
			acc = h3 * ONE_Q9 + (h1 - h3) * (ONE_Q9 - fz) + (h2 - h3) * (ONE_Q9 - fx);
		res = (acc + HALF_Q9) >>> FRAC_BITS;
		if (res > OUT_MAX)
			res = OUT_MAX;
		if (res < OUT_MIN)
			res = OUT_MIN;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Queue a sample write; the position fields carry junk.
	task automatic push_write(int r, int c, logic signed [SAMPLE_W-1:0] s);
		grid_word_t w;
		w.action = ACT_WRITE;
		w.row    = r;
		w.col    = c;
		w.sample = s;
		w.x_pos  = $urandom;
		w.z_pos  = $urandom;
		sample_written[r * GRID_COLS + c] = 1'b1;
		pending_words.push_back(w);
	endtask

	// Queue a query, preceded by writes for any corner not yet written so
	// that no undefined store entry is ever read.
	task automatic push_query(logic signed [POS_W-1:0] xp, logic signed [POS_W-1:0] zp);
		grid_word_t w;
		longint cx, cz, r, c;
		cx = cell_col(xp);
		cz = cell_row(zp);
		for (r = cz; r <= cz + 1; r++)
			for (c = cx; c <= cx + 1; c++)
				if (!sample_written[r * GRID_COLS + c])
					push_write(r, c, $urandom);
		w.action = ACT_QUERY;
		w.row    = $urandom;
		w.col    = $urandom;
		w.sample = $urandom;
		w.x_pos  = xp;
		w.z_pos  = zp;
		pending_words.push_back(w);
	endtask

	// Mostly land inside the grid in use (with a cell of margin for
	// extrapolation), sometimes anywhere, sometimes at the range ends.
	function automatic logic signed [POS_W-1:0] pick_pos(logic signed [POS_W-1:0] offset,
			longint cells);
		int pick;
		longint target;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			target = longint'($urandom_range(0, (cells + 2) * ONE_Q9)) - ONE_Q9;
			return target - longint'(offset) + HALF_Q9;
		end
		if (pick < 90)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic random_words(int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 40)
				push_write($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
					$urandom);
			else
				push_query(pick_pos(x_offset_reg, used_size(columns_reg, COLS_MIN, GRID_COLS)),
					pick_pos(z_offset_reg, used_size(rows_reg, ROWS_MIN, GRID_ROWS)));
		end
	endtask

	// Hold until every word is sent and every height has come back, then
	// let the pipe flush the trailing writes.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_heights.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] xo, logic [CFG_DATA_W-1:0] zo,
			logic [GRID_REG_W-1:0] ncols, logic [GRID_REG_W-1:0] nrows);
		write_reg(CFG_X_OFFSET, xo);
		write_reg(CFG_Z_OFFSET, zo);
		write_reg(CFG_GRID_COLUMNS, ncols);
		write_reg(CFG_GRID_ROWS, nrows);
		random_words(PHASE_WORDS);
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset configuration.
		// Opposite extremes on the first cell so far-off queries saturate.
		push_write(0, 1, SAMPLE_MAX);
		push_write(0, 2, SAMPLE_MIN);
		push_write(1, 1, SAMPLE_MIN);
		push_write(1, 2, SAMPLE_MAX);
		push_query(768, 256);                // exactly on a corner
		push_query(768 + 300, 256 + 211);    // just inside the lower triangle
		push_query(768 + 300, 256 + 212);    // on the diagonal: upper triangle
		push_query(-44, -44);                // negative coordinate truncates to zero
		push_query(POS_MIN, 256);            // far left: saturates high
		push_query(POS_MIN, POS_MIN);
		push_query(POS_MAX, POS_MAX);        // clamped to the last cell
		push_query(POS_MAX, POS_MIN);
		push_query(POS_MIN, POS_MAX);
		// write followed, after fills of the other corners, by a query that reads it
		push_write(5, 5, $urandom);
		push_query(5 * ONE_Q9 + 356, 5 * ONE_Q9 + 306);
		drain();

		// Offsets at both extremes, grid at its smallest.
		run_phase({1'b0, {(CFG_DATA_W-1){1'b1}}}, {1'b1, {(CFG_DATA_W-1){1'b0}}}, 3, 2);
		// Sizes above and below the supported range saturate.
		run_phase({1'b1, {(CFG_DATA_W-1){1'b0}}}, {1'b0, {(CFG_DATA_W-1){1'b1}}}, '1, 0);
		// Drop a write to a register that does not exist.
		write_reg(CFG_UNMAPPED, $urandom);
		run_phase($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096, 1, 129);
		run_phase($urandom, $urandom, $urandom_range(COLS_MIN, GRID_COLS),
			$urandom_range(ROWS_MIN, GRID_ROWS));
		run_phase($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
			GRID_RESET, GRID_RESET);

		if (expected_heights.size() != 0) begin
			$display("%0t ns: %0d heights never arrived", $time, expected_heights.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input driver: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	logic       in_fire = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	grid_word_t next_word;

	always @(posedge clk)
		in_fire <= in_valid && in_ready;

	always @(negedge clk) begin
		// Advance only when the line is free or the last word was taken.
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				action    <= next_word.action;
				row       <= next_word.row;
				col       <= next_word.col;
				sample    <= next_word.sample;
				x_pos     <= next_word.x_pos;
				z_pos     <= next_word.z_pos;
				in_valid  <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// now and then a long run with no gap at all
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output back-pressure: switch between stall patterns every so often
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = READY_ALWAYS;
	int          stall_span = 0;
	int          stall_tick = 0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(READY_ALWAYS, READY_EVERY_THIRD));
			stall_span = $urandom_range(10, 80);
		end else begin
			stall_span--;
		end
		stall_tick++;
		case (stall_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_COIN:   out_ready <= $urandom_range(0, 1);
			READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:      out_ready <= (stall_tick % 3 == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Prediction: track accepted config and input words
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_OFFSET:     x_offset_reg = cfg_data;
				CFG_Z_OFFSET:     z_offset_reg = cfg_data;
				CFG_GRID_COLUMNS: columns_reg = cfg_data[GRID_REG_W-1:0];
				CFG_GRID_ROWS:    rows_reg = cfg_data[GRID_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (action == ACT_WRITE)
				model_heights[int'(row) * GRID_COLS + int'(col)] = sample;
			else
				expected_heights.push_back(interp_height(x_pos, z_pos));
		end
	end

	// ------------------------------------------------------------------
	// Checking: compare each delivered height with the oldest expectation
	// ------------------------------------------------------------------
	logic signed [POS_W-1:0] want_height;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_heights.size() == 0) begin
				$display("%0t ns: unexpected height_out, expected none, got %0d",
					$time, height_out);
				fail_count++;
			end else begin
				want_height = expected_heights.pop_front();
				if (height_out !== want_height) begin
					$display("%0t ns: height_out mismatch, expected %0d, got %0d",
						$time, want_height, height_out);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no word moves on any channel for too long
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_MAX) begin
			$display("%0t ns: watchdog, no word moved for %0d cycles", $time, idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
